// ----- hdl/hermite_fractional_delay_line_defines.svh -----
// Assertion macros for the fractional delay line checker.
// Both expect clk and rst in the scope of use.
`ifndef HERMITE_FRACTIONAL_DELAY_LINE_DEFINES_SVH
`define HERMITE_FRACTIONAL_DELAY_LINE_DEFINES_SVH

// Same-cycle implication.
`define HFDL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HFDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hfdl_pkg.sv -----
package hfdl_pkg;

  localparam int DEPTH_DEFAULT         = 524288;
  localparam int CHANNELS_DEFAULT      = 2;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int SAMPLE_W = 24;
  localparam int DIST_W   = 35;

  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DIST_W-1:0]          distance_t;

endpackage

// ----- hdl/hfdl_in_if.sv -----
interface hfdl_in_if import hfdl_pkg::*; ();

  logic      valid;
  logic      ready;
  logic      channel_select;
  distance_t read_distance;
  sample_t   write_sample;
  logic      advance_frame;

  modport source (
    output valid, channel_select, read_distance, write_sample, advance_frame,
    input  ready
  );

  modport sink (
    input  valid, channel_select, read_distance, write_sample, advance_frame,
    output ready
  );

endinterface

// ----- hdl/hfdl_out_if.sv -----
interface hfdl_out_if import hfdl_pkg::*; ();

  logic    valid;
  logic    ready;
  sample_t read_sample;
  logic    beyond_history;

  modport source (
    output valid, read_sample, beyond_history,
    input  ready
  );

  modport sink (
    input  valid, read_sample, beyond_history,
    output ready
  );

endinterface

// ----- hdl/hfdl_ram.sv -----
module hfdl_ram import hfdl_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = CHANNELS_DEFAULT * DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hermite_fractional_delay_line.sv -----
// Channel  Dir  Payload                                              Transfer
// req      in   channel_select, read_distance, write_sample,         valid & ready
//               advance_frame
// rsp      out  read_sample, beyond_history                          valid & ready
//
// A new req is taken only after the previous item is loaded into rsp. Each
// item fetches the four taps one per cycle from the sample RAM, then runs the
// three Horner multiplies through one multiplier; a read past recorded history
// skips both. Reset starts a clearing pass that zeroes the RAM's CHANNELS *
// 2^ceil(log2(DEPTH)) words (1048576 at the defaults), holding req.ready low.
// A stalled rsp holds its result; the next item may be taken meanwhile.
module hermite_fractional_delay_line import hfdl_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int CHANNELS      = CHANNELS_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  hfdl_in_if.sink    req,
  hfdl_out_if.source rsp
);

  localparam int IW   = $clog2(DEPTH);
  localparam int FCW  = $clog2(DEPTH + 1);
  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEMD = CHANNELS << IW;
  localparam int AW   = $clog2(MEMD);
  localparam int PW   = IW + FRACTION_BITS + 1;
  localparam int DW   = (PW > DIST_W + 1) ? PW : DIST_W + 1;
  localparam int C1W  = SAMPLE_W + 1;
  localparam int C2W  = SAMPLE_W + 4;
  localparam int C3W  = SAMPLE_W + 3;
  localparam int TW   = SAMPLE_W + 6;
  localparam int PRW  = TW + FRACTION_BITS + 1;
  localparam int SW   = TW + 2;

  localparam logic [DW-1:0]  ONE_D     = DW'(1) << FRACTION_BITS;
  localparam logic [DW-1:0]  SPAN_M1_D = (DW'(DEPTH) << FRACTION_BITS) - ONE_D;
  localparam logic [PW-1:0]  SPAN_P    = PW'(DEPTH) << FRACTION_BITS;
  localparam logic [IW-1:0]  IDX_LAST  = IW'(DEPTH - 1);
  localparam logic [FCW-1:0] FILL_MAX  = FCW'(DEPTH);
  localparam logic [AW-1:0]  CLR_LAST  = AW'(MEMD - 1);
  localparam logic [2:0]     TAP_LAST  = 3'd4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_COEF  = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL3  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]               state;
  logic                     clearing;
  logic [AW-1:0]            clr_addr;
  logic [IW-1:0]            wp;
  logic [FCW-1:0]           filled;

  logic [CW-1:0]            ch;
  distance_t                rd_dist;
  sample_t                  wsample;
  logic                     adv;
  logic                     flag;
  logic [PW-1:0]            q;
  logic [IW-1:0]            rd_idx;
  logic [FRACTION_BITS-1:0] frac;
  logic [2:0]               cnt;
  sample_t                  y [4];
  logic signed [C1W-1:0]    c1;
  logic signed [C2W-1:0]    c2;
  logic signed [C3W-1:0]    c3;
  logic signed [PRW-1:0]    acc;

  logic                     out_valid;
  sample_t                  out_sample;
  logic                     out_beyond;

  logic [CW-1:0]            ch_in;
  logic [DW-1:0]            d_cl;
  logic                     flag_calc;
  logic [PW-1:0]            qraw;
  logic [PW-1:0]            q_wrap;
  logic signed [TW-1:0]     mul_a;
  logic signed [FRACTION_BITS:0] mul_f;
  logic signed [TW-1:0]     t3;
  logic signed [SW-1:0]     sum_v;
  logic signed [SW-1:0]     res_w;
  sample_t                  res;
  logic signed [C1W-1:0]    d12;
  logic                     load_out;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [SAMPLE_W-1:0]      ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [SAMPLE_W-1:0]      ram_rdata;

  hfdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEMD)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready          = (state == S_IDLE) && !clearing;
  assign rsp.valid          = out_valid;
  assign rsp.read_sample    = out_sample;
  assign rsp.beyond_history = out_beyond;
  assign load_out           = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    ram_we    = clearing || ((state == S_FETCH) && (cnt == TAP_LAST));
    ram_waddr = clearing ? clr_addr : AW'({ch, wp});
    ram_wdata = clearing ? '0 : wsample;
    ram_raddr = AW'({ch, rd_idx});
  end

  always_comb begin
    ch_in = CW'(req.channel_select);
    if (32'(ch_in) >= CHANNELS) begin
      ch_in = CW'(CHANNELS - 1);
    end
    d_cl      = (DW'(rd_dist) < ONE_D) ? ONE_D : DW'(rd_dist);
    flag_calc = (d_cl + ONE_D) > (DW'(filled) << FRACTION_BITS);
    // index of the oldest tap (i1 - 1), before wrapping
    qraw      = PW'((DW'(wp) << FRACTION_BITS) + SPAN_M1_D - d_cl);
    q_wrap    = (q >= SPAN_P) ? q - SPAN_P : q;
  end

  always_comb begin
    mul_f = signed'({1'b0, frac});
    case (state)
      S_MUL2:  mul_a = TW'(acc >>> FRACTION_BITS) + TW'(c2);
      S_MUL3:  mul_a = TW'(acc >>> FRACTION_BITS) + TW'(c1);
      default: mul_a = TW'(c3);
    endcase
    t3    = TW'(acc >>> FRACTION_BITS);
    sum_v = (SW'(y[1]) <<< 1) + SW'(t3) + SW'(1);
    res_w = sum_v >>> 1;
    if (res_w > SW'(SAMPLE_MAX)) begin
      res = sample_t'(SAMPLE_MAX);
    end else if (res_w < SW'(SAMPLE_MIN)) begin
      res = sample_t'(SAMPLE_MIN);
    end else begin
      res = SAMPLE_W'(res_w);
    end
    d12 = C1W'(y[1]) - C1W'(y[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      wp        <= '0;
      filled    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == CLR_LAST) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            ch      <= ch_in;
            rd_dist <= req.read_distance;
            wsample <= req.write_sample;
            adv     <= req.advance_frame;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          flag <= flag_calc;
          q    <= qraw;
          if (flag_calc) begin
            cnt   <= TAP_LAST;
            state <= S_FETCH;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          rd_idx <= IW'(q_wrap >> FRACTION_BITS);
          frac   <= FRACTION_BITS'(q_wrap);
          cnt    <= '0;
          state  <= S_FETCH;
        end
        S_FETCH: begin
          if (cnt != 3'd0) begin
            y[2'(cnt - 3'd1)] <= ram_rdata;
          end
          rd_idx <= (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
          cnt    <= cnt + 3'd1;
          if (cnt == TAP_LAST) begin
            // new sample goes in after all taps are read
            if (adv) begin
              wp <= (wp == IDX_LAST) ? '0 : wp + 1'b1;
              if (filled < FILL_MAX) begin
                filled <= filled + 1'b1;
              end
            end
            state <= flag ? S_DONE : S_COEF;
          end
        end
        S_COEF: begin
          c1    <= C1W'(y[2]) - C1W'(y[0]);
          c2    <= (C2W'(y[0]) <<< 1) - (C2W'(y[1]) <<< 2) - C2W'(y[1])
                   + (C2W'(y[2]) <<< 2) - C2W'(y[3]);
          c3    <= C3W'(y[3]) - C3W'(y[0]) + (C3W'(d12) <<< 1) + C3W'(d12);
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= mul_a * mul_f;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= mul_a * mul_f;
          state <= S_MUL3;
        end
        S_MUL3: begin
          acc   <= mul_a * mul_f;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_sample <= flag ? '0 : res;
            out_beyond <= flag;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/hfdl_checker.sv -----
`include "hermite_fractional_delay_line_defines.svh"

module hfdl_checker import hfdl_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_sample,
  input logic    out_beyond
);

  logic [1:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  `HFDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_beyond), "stalled result changed")
  `HFDL_ASSERT_IMPLY(a_no_phantom, out_valid, pending != 2'd0, "result without an outstanding item")
  `HFDL_ASSERT_IMPLY(a_no_overrun, in_xfer, pending != 2'd2, "item taken with two results owed")
  `HFDL_ASSERT_IMPLY(a_beyond_zero, out_valid && out_beyond, out_sample == '0, "beyond history with nonzero sample")
  `HFDL_ASSERT_IMPLY(a_clear_blocks, $past(rst), !in_ready, "ready during memory clear")

endmodule

bind hermite_fractional_delay_line hfdl_checker u_hfdl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_sample (rsp.read_sample),
  .out_beyond (rsp.beyond_history)
);
